// ----- rtl/drt_pkg.sv -----
// ----------------------------------------------------------------------------
// drt_pkg
// Shared types, constants and rectangle helpers for the dirty region tracker.
// ----------------------------------------------------------------------------
package drt_pkg;

   localparam int MAX_RECTS = 16;
   localparam int IDX_W     = $clog2(MAX_RECTS);
   localparam int CNT_W     = $clog2(MAX_RECTS + 1);
   localparam int COORD_W   = 15;
   localparam int COUNT_OUT_W = 5;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_ADD   = 2'd1,
      CMD_READ  = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef enum logic [0:0] {
      REG_SCREEN_WIDTH  = 1'b0,
      REG_SCREEN_HEIGHT = 1'b1
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADD,
      ST_SC_I,
      ST_SC_C,
      ST_CP_I,
      ST_CP_A,
      ST_CP_J,
      ST_CP_B,
      ST_CP_SH,
      ST_CP_SW,
      ST_RD_I,
      ST_RD_O,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [COORD_W-1:0] h;
      logic [COORD_W-1:0] w;
      logic [COORD_W-1:0] t;
      logic [COORD_W-1:0] l;
   } box_type;

   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] waddr;
      box_type          wdata;
      logic             re;
      logic [IDX_W-1:0] raddr;
   } ram_req_type;

   // strict half-open intersection
   function automatic logic boxes_overlap(box_type a, box_type b);
      logic [COORD_W:0] ar, br, ab, bb;
      ar = {1'b0, a.l} + {1'b0, a.w};
      br = {1'b0, b.l} + {1'b0, b.w};
      ab = {1'b0, a.t} + {1'b0, a.h};
      bb = {1'b0, b.t} + {1'b0, b.h};
      return ({1'b0, a.l} < br) && ({1'b0, b.l} < ar) &&
             ({1'b0, a.t} < bb) && ({1'b0, b.t} < ab);
   endfunction

   function automatic box_type bound_box(box_type a, box_type b);
      logic [COORD_W:0] ar, br, ab, bb, rr, rb;
      box_type r;
      ar  = {1'b0, a.l} + {1'b0, a.w};
      br  = {1'b0, b.l} + {1'b0, b.w};
      ab  = {1'b0, a.t} + {1'b0, a.h};
      bb  = {1'b0, b.t} + {1'b0, b.h};
      rr  = (ar > br) ? ar : br;
      rb  = (ab > bb) ? ab : bb;
      r.l = (a.l < b.l) ? a.l : b.l;
      r.t = (a.t < b.t) ? a.t : b.t;
      r.w = COORD_W'(rr - {1'b0, r.l});
      r.h = COORD_W'(rb - {1'b0, r.t});
      return r;
   endfunction

endpackage

// ----- rtl/drt_req_if.sv -----
// ----------------------------------------------------------------------------
// drt_req_if
// Command channel: valid/ready with the command and a signed rectangle.
// ----------------------------------------------------------------------------
interface drt_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         cmd;
   logic signed [15:0] rect_left;
   logic signed [15:0] rect_top;
   logic signed [15:0] rect_width;
   logic signed [15:0] rect_height;

   modport source (output valid, cmd, rect_left, rect_top, rect_width, rect_height,
                   input ready);
   modport sink   (input valid, cmd, rect_left, rect_top, rect_width, rect_height,
                   output ready);
endinterface

// ----- rtl/drt_rsp_if.sv -----
// ----------------------------------------------------------------------------
// drt_rsp_if
// Result channel: valid/ready with one listed rectangle or a status word.
// ----------------------------------------------------------------------------
interface drt_rsp_if;
   logic        valid;
   logic        ready;
   logic [14:0] out_left;
   logic [14:0] out_top;
   logic [14:0] out_width;
   logic [14:0] out_height;
   logic        entry_valid;
   logic [4:0]  list_count;
   logic        overflowed;
   logic        last;

   modport source (output valid, out_left, out_top, out_width, out_height,
                   entry_valid, list_count, overflowed, last, input ready);
   modport sink   (input valid, out_left, out_top, out_width, out_height,
                   entry_valid, list_count, overflowed, last, output ready);
endinterface

// ----- rtl/dirty_region_tracker.sv -----
// ----------------------------------------------------------------------------
// dirty_region_tracker
// Keeps a list of up to MAX_RECTS screen update rectangles in one memory.
// ----------------------------------------------------------------------------
// One command is worked at a time; the rectangle memory has one read and one
// write port, and every memory visit reads, then uses the registered data.
// Clear, unused command and read of an empty list: the sequencer goes to the
// emit state, which loads the status transaction into the output register
// once that is free, and then returns to idle for the next command.
// Read: each stored rectangle is read, then loaded into the output register
// once that is free. Add: after the drop and overflow check, the list is
// scanned entry by entry for a merge target, then compacted by pair tests and
// by shifting entries down, restarting from the top after every merge. A new
// command is taken as soon as the sequencer is idle, even while the last
// result still waits in the output register.
module dirty_region_tracker (
   input  logic                        clock,
   input  logic                        reset,
   drt_req_if.sink                     req_if,
   drt_rsp_if.source                   rsp_if,
   input  logic                        csr_we,
   input  logic [0:0]                  csr_index,
   input  logic [drt_pkg::COORD_W-1:0] csr_wdata
);

   logic [drt_pkg::COORD_W-1:0] screen_w_ff, screen_h_ff;
   drt_pkg::ram_req_type ram_req;
   drt_pkg::box_type     ram_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_w_ff <= drt_pkg::COORD_W'(320);
         screen_h_ff <= drt_pkg::COORD_W'(240);
      end else if (csr_we) begin
         case (drt_pkg::reg_index_type'(csr_index))
            drt_pkg::REG_SCREEN_WIDTH:  screen_w_ff <= csr_wdata;
            drt_pkg::REG_SCREEN_HEIGHT: screen_h_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   drt_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .screen_w  (screen_w_ff),
      .screen_h  (screen_h_ff),
      .ram_req   (ram_req),
      .ram_rdata (ram_rdata)
   );

   drt_rect_ram u_ram (
      .clock     (clock),
      .ram_req   (ram_req),
      .ram_rdata (ram_rdata)
   );

endmodule

// ----- rtl/drt_rect_ram.sv -----
// ----------------------------------------------------------------------------
// drt_rect_ram
// Rectangle list storage: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module drt_rect_ram (
   input  logic                  clock,
   input  drt_pkg::ram_req_type  ram_req,
   output drt_pkg::box_type      ram_rdata
);

   drt_pkg::box_type mem [drt_pkg::MAX_RECTS];
   drt_pkg::box_type rdata_ff;

   always_ff @(posedge clock) begin
      if (ram_req.we) begin
         mem[ram_req.waddr] <= ram_req.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_req.re) begin
         rdata_ff <= mem[ram_req.raddr];
      end
   end

   assign ram_rdata = rdata_ff;

endmodule

// ----- rtl/drt_seq.sv -----
// ----------------------------------------------------------------------------
// drt_seq
// Command sequencer: clip, merge scan, list compaction and read-out over the
// rectangle memory, plus the result output register.
// ----------------------------------------------------------------------------
module drt_seq (
   input  logic                          clock,
   input  logic                          reset,
   drt_req_if.sink                       req_if,
   drt_rsp_if.source                     rsp_if,
   input  logic [drt_pkg::COORD_W-1:0]   screen_w,
   input  logic [drt_pkg::COORD_W-1:0]   screen_h,
   output drt_pkg::ram_req_type          ram_req,
   input  drt_pkg::box_type              ram_rdata
);

   localparam int CW = drt_pkg::CNT_W;
   localparam int IW = drt_pkg::IDX_W;

   drt_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   drt_pkg::box_type nb_ff, nb_in, a_ff, a_in;
   logic drop_ff, drop_in, ovf_ff, ovf_in;

   logic rsp_valid_ff, rsp_valid_in;
   drt_pkg::box_type out_box_ff, out_box_in;
   logic out_entry_ff, out_entry_in, out_ovf_ff, out_ovf_in, out_last_ff, out_last_in;
   logic [drt_pkg::COUNT_OUT_W-1:0] out_count_ff, out_count_in;

   // clip of the incoming rectangle in 18-bit signed arithmetic
   logic signed [17:0] cx, cy, cw, ch, cx2, cy2, cx1c, cy1c, cx2c, cy2c, sw_s, sh_s;
   logic clip_drop;
   drt_pkg::box_type clip_box, full_box;
   logic out_free, accept;

   always_comb begin
      cx   = 18'(req_if.rect_left);
      cy   = 18'(req_if.rect_top);
      cw   = 18'(req_if.rect_width);
      ch   = 18'(req_if.rect_height);
      sw_s = 18'($signed({1'b0, screen_w}));
      sh_s = 18'($signed({1'b0, screen_h}));
      cx2  = cx + cw;
      cy2  = cy + ch;
      cx1c = (cx < 0) ? 18'sd0 : cx;
      cy1c = (cy < 0) ? 18'sd0 : cy;
      cx2c = (cx2 > sw_s) ? sw_s : cx2;
      cy2c = (cy2 > sh_s) ? sh_s : cy2;
      clip_drop = (cw <= 0) || (ch <= 0) || (cx1c >= cx2c) || (cy1c >= cy2c);
      clip_box.l = cx1c[14:0];
      clip_box.t = cy1c[14:0];
      clip_box.w = 15'(cx2c - cx1c);
      clip_box.h = 15'(cy2c - cy1c);
      full_box.l = '0;
      full_box.t = '0;
      full_box.w = screen_w;
      full_box.h = screen_h;
   end

   assign out_free      = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready  = (state_ff == drt_pkg::ST_IDLE);
   assign accept        = req_if.valid && req_if.ready;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      nb_in        = nb_ff;
      a_in         = a_ff;
      drop_in      = drop_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      out_box_in   = out_box_ff;
      out_entry_in = out_entry_ff;
      out_ovf_in   = out_ovf_ff;
      out_last_in  = out_last_ff;
      out_count_in = out_count_ff;
      ram_req      = '0;

      case (state_ff)
         drt_pkg::ST_IDLE: begin
            if (accept) begin
               ovf_in = 1'b0;
               case (drt_pkg::cmd_type'(req_if.cmd))
                  drt_pkg::CMD_CLEAR: begin
                     count_in = '0;
                     state_in = drt_pkg::ST_EMIT;
                  end
                  drt_pkg::CMD_ADD: begin
                     nb_in    = clip_box;
                     drop_in  = clip_drop;
                     state_in = drt_pkg::ST_ADD;
                  end
                  drt_pkg::CMD_READ: begin
                     k_in     = '0;
                     state_in = (count_ff == '0) ? drt_pkg::ST_EMIT : drt_pkg::ST_RD_I;
                  end
                  default: state_in = drt_pkg::ST_EMIT;
               endcase
            end
         end
         drt_pkg::ST_ADD: begin
            if (drop_ff) begin
               state_in = drt_pkg::ST_EMIT;
            end else if (count_ff >= CW'(drt_pkg::MAX_RECTS)) begin
               ram_req.we    = 1'b1;
               ram_req.waddr = '0;
               ram_req.wdata = full_box;
               count_in      = CW'(1);
               ovf_in        = 1'b1;
               state_in      = drt_pkg::ST_EMIT;
            end else begin
               i_in     = '0;
               state_in = drt_pkg::ST_SC_I;
            end
         end
         drt_pkg::ST_SC_I: begin
            if (i_ff >= count_ff) begin
               ram_req.we    = 1'b1;
               ram_req.waddr = count_ff[IW-1:0];
               ram_req.wdata = nb_ff;
               count_in      = count_ff + CW'(1);
               i_in          = '0;
               state_in      = drt_pkg::ST_CP_I;
            end else begin
               ram_req.re    = 1'b1;
               ram_req.raddr = i_ff[IW-1:0];
               state_in      = drt_pkg::ST_SC_C;
            end
         end
         drt_pkg::ST_SC_C: begin
            if (drt_pkg::boxes_overlap(ram_rdata, nb_ff)) begin
               ram_req.we    = 1'b1;
               ram_req.waddr = i_ff[IW-1:0];
               ram_req.wdata = drt_pkg::bound_box(ram_rdata, nb_ff);
               i_in          = '0;
               state_in      = drt_pkg::ST_CP_I;
            end else begin
               i_in     = i_ff + CW'(1);
               state_in = drt_pkg::ST_SC_I;
            end
         end
         // compaction: first overlapping pair (i, j) merges into i, tail shifts down
         drt_pkg::ST_CP_I: begin
            if ((i_ff + CW'(1)) >= count_ff) begin
               state_in = drt_pkg::ST_EMIT;
            end else begin
               ram_req.re    = 1'b1;
               ram_req.raddr = i_ff[IW-1:0];
               state_in      = drt_pkg::ST_CP_A;
            end
         end
         drt_pkg::ST_CP_A: begin
            a_in     = ram_rdata;
            j_in     = i_ff + CW'(1);
            state_in = drt_pkg::ST_CP_J;
         end
         drt_pkg::ST_CP_J: begin
            if (j_ff >= count_ff) begin
               i_in     = i_ff + CW'(1);
               state_in = drt_pkg::ST_CP_I;
            end else begin
               ram_req.re    = 1'b1;
               ram_req.raddr = j_ff[IW-1:0];
               state_in      = drt_pkg::ST_CP_B;
            end
         end
         drt_pkg::ST_CP_B: begin
            if (drt_pkg::boxes_overlap(a_ff, ram_rdata)) begin
               ram_req.we    = 1'b1;
               ram_req.waddr = i_ff[IW-1:0];
               ram_req.wdata = drt_pkg::bound_box(a_ff, ram_rdata);
               k_in          = j_ff;
               state_in      = drt_pkg::ST_CP_SH;
            end else begin
               j_in     = j_ff + CW'(1);
               state_in = drt_pkg::ST_CP_J;
            end
         end
         drt_pkg::ST_CP_SH: begin
            if ((k_ff + CW'(1)) >= count_ff) begin
               count_in = count_ff - CW'(1);
               i_in     = '0;
               state_in = drt_pkg::ST_CP_I;
            end else begin
               ram_req.re    = 1'b1;
               ram_req.raddr = IW'(k_ff + CW'(1));
               state_in      = drt_pkg::ST_CP_SW;
            end
         end
         drt_pkg::ST_CP_SW: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = k_ff[IW-1:0];
            ram_req.wdata = ram_rdata;
            k_in          = k_ff + CW'(1);
            state_in      = drt_pkg::ST_CP_SH;
         end
         drt_pkg::ST_RD_I: begin
            ram_req.re    = 1'b1;
            ram_req.raddr = k_ff[IW-1:0];
            state_in      = drt_pkg::ST_RD_O;
         end
         drt_pkg::ST_RD_O: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_box_in   = ram_rdata;
               out_entry_in = 1'b1;
               out_ovf_in   = 1'b0;
               out_count_in = drt_pkg::COUNT_OUT_W'(count_ff);
               out_last_in  = ((k_ff + CW'(1)) == count_ff);
               k_in         = k_ff + CW'(1);
               state_in     = out_last_in ? drt_pkg::ST_IDLE : drt_pkg::ST_RD_I;
            end
         end
         drt_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_box_in   = '0;
               out_entry_in = 1'b0;
               out_ovf_in   = ovf_ff;
               out_count_in = drt_pkg::COUNT_OUT_W'(count_ff);
               out_last_in  = 1'b1;
               state_in     = drt_pkg::ST_IDLE;
            end
         end
         default: state_in = drt_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= drt_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff         <= i_in;
      j_ff         <= j_in;
      k_ff         <= k_in;
      nb_ff        <= nb_in;
      a_ff         <= a_in;
      drop_ff      <= drop_in;
      ovf_ff       <= ovf_in;
      out_box_ff   <= out_box_in;
      out_entry_ff <= out_entry_in;
      out_ovf_ff   <= out_ovf_in;
      out_last_ff  <= out_last_in;
      out_count_ff <= out_count_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.out_left    = out_box_ff.l;
   assign rsp_if.out_top     = out_box_ff.t;
   assign rsp_if.out_width   = out_box_ff.w;
   assign rsp_if.out_height  = out_box_ff.h;
   assign rsp_if.entry_valid = out_entry_ff;
   assign rsp_if.list_count  = out_count_ff;
   assign rsp_if.overflowed  = out_ovf_ff;
   assign rsp_if.last        = out_last_ff;

endmodule

// ----- rtl/drt_check.sv -----
// ----------------------------------------------------------------------------
// drt_check
// Port-level checks on the result channel of the dirty region tracker.
// ----------------------------------------------------------------------------
module drt_check (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       entry_valid,
   input logic [4:0] list_count,
   input logic       overflowed,
   input logic       last
);

   // a stalled transaction stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   a_entry_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && entry_valid |-> list_count != 5'd0)
      else $error("listed rectangle with empty list count");

   // full-screen collapse leaves exactly one rectangle
   a_ovf_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && overflowed |-> list_count == 5'd1 && !entry_valid && last)
      else $error("overflow status malformed");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !entry_valid |-> last)
      else $error("status transaction without last");

endmodule

bind dirty_region_tracker drt_check u_drt_check (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .entry_valid (rsp_if.entry_valid),
   .list_count  (rsp_if.list_count),
   .overflowed  (rsp_if.overflowed),
   .last        (rsp_if.last)
);
